### rtl/mas_pkg.sv
`default_nettype none
package mas_pkg;

  localparam int unsigned AlarmSlots    = 16;
  localparam int unsigned CallbackSlots = 20;
  localparam int unsigned SlotBits      = 4;
  localparam int unsigned CountBits     = 5;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;
  localparam logic [1:0] REQ_UPDATE = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_POS  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [31:0] atime;
    logic [23:0] period;
    logic [15:0] tag;
    logic        kind;
    logic [4:0]  cb;
  } slot_t;

  // per-cycle command to the cell row
  typedef struct packed {
    logic        load;      // write slot at 'idx'
    logic [3:0]  idx;
    slot_t       data;
    logic        pull;      // shift cells at and above 'idx' down by one
    logic        bubble_en; // one odd-even sort pass
    logic        bubble_odd;
  } cell_cmd_t;

endpackage
`default_nettype wire

### rtl/mas_cell.sv
`default_nettype none
// one table slot; swaps with the upper neighbor during a sort pass
module mas_cell (
  input  wire logic            clk,
  input  wire logic [3:0]      my_idx,
  input  wire mas_pkg::cell_cmd_t cmd,
  input  wire mas_pkg::slot_t  lower,
  input  wire mas_pkg::slot_t  upper,
  input  wire logic            lower_swap,
  input  wire logic            up_in_range,
  output mas_pkg::slot_t       slot,
  output logic                 swap_up
);
  logic pair_lead;

  // this cell leads a pair when its index parity matches the pass and its upper neighbor holds an entry
  assign pair_lead = (my_idx[0] == cmd.bubble_odd) && up_in_range;
  assign swap_up   = cmd.bubble_en && pair_lead && (slot.atime > upper.atime);

  always_ff @(posedge clk) begin
    if (cmd.load && cmd.idx == my_idx) begin
      slot <= cmd.data;
    end else if (cmd.pull && my_idx >= cmd.idx) begin
      slot <= upper;
    end else if (swap_up) begin
      slot <= upper;
    end else if (lower_swap) begin
      slot <= lower;
    end
  end
endmodule
`default_nettype wire

### rtl/mas_divider.sv
`default_nettype none
// restoring divider, one quotient bit a cycle
module mas_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [23:0] divisor,
  output logic             busy,
  output logic [31:0]      quotient
);
  logic [5:0]  cnt;
  logic [24:0] rem;
  logic [24:0] trial;
  logic [23:0] dvs;

  assign trial = {rem[23:0], quotient[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= 6'd32;
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      if (trial[24]) begin
        rem      <= {rem[23:0], quotient[31]};
        quotient <= {quotient[30:0], 1'b0};
      end else begin
        rem      <= trial;
        quotient <= {quotient[30:0], 1'b1};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

### rtl/multi_alarm_scheduler.sv
`default_nettype none
// channel   direction  handshake          payload
// request   in         valid / stall      req_type .. position
// result    out        out_valid/out_stall status .. last
// config    in         apb psel/penable   grace_seconds at address 0
//
// add/delete: an execute step, then 17 odd-even sort passes
// update: an extra step re-inserts the entry at the end of the row before the sort
// tick: a count pass over the entries, a scan step per entry, and for each due repeating
//   alarm a divide setup, the divide wait and an advance; then 17 sort passes and
//   an empty result when nothing fired
// rst clears the fill count, the sequencer and grace_seconds (to 2)
// while a result waits under out_stall the sequencer holds before the next result; one item at a time
module multi_alarm_scheduler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  output logic             stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [31:0] now_seconds,
  input  wire logic [31:0] alarm_time,
  input  wire logic [23:0] period_seconds,
  input  wire logic [15:0] message_tag,
  input  wire logic        is_callback,
  input  wire logic [4:0]  callback_number,
  input  wire logic [3:0]  position,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic             fired,
  output logic [31:0]      out_time,
  output logic [15:0]      out_tag,
  output logic             out_is_callback,
  output logic [4:0]       out_callback_number,
  output logic             last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_ADV    = 4'd4;
  localparam logic [3:0] S_SORT   = 4'd5;
  localparam logic [3:0] S_RESULT = 4'd6;
  localparam logic [3:0] S_DIVW   = 4'd8;
  localparam logic [3:0] S_COUNT  = 4'd9;
  localparam logic [3:0] S_UPDL   = 4'd10;

  logic [3:0]  state;
  logic [7:0]  grace;
  logic [4:0]  count;
  logic [4:0]  scan;       // scan position, can reach count
  logic [4:0]  passes;
  logic [4:0]  nfire;      // fires still to report in this tick
  logic        any_fire;
  logic [1:0]  rq;
  logic [31:0] now_r, at_r;
  logic [23:0] per_r;
  logic [15:0] tag_r;
  logic        kind_r;
  logic [4:0]  cb_r;
  logic [3:0]  pos_r;

  mas_pkg::cell_cmd_t cmd;
  mas_pkg::slot_t     slots [mas_pkg::AlarmSlots];
  logic               swaps [mas_pkg::AlarmSlots];
  mas_pkg::slot_t     cur;
  mas_pkg::slot_t     upd_r;   // updated entry waiting to re-enter at the end
  logic [31:0]        late;
  logic               due;
  logic               div_start, div_busy;
  logic [31:0]        quot;
  logic [56:0]        prod;
  logic [56:0]        prod_r;
  logic [57:0]        nt;
  logic [32:0]        jumps;
  logic               out_ready_ok;
  logic               out_load;

  // ---- config port
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {24'd0, grace} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) grace <= 8'd2;
    else if (psel && penable && pwrite && paddr == 2'd0) grace <= pwdata[7:0];
  end

  // ---- cell row
  genvar g;
  generate
    for (g = 0; g < mas_pkg::AlarmSlots; g++) begin : g_row
      localparam int unsigned Lo = (g == 0) ? 0 : g - 1;
      localparam int unsigned Hi = (g == mas_pkg::AlarmSlots - 1) ? g : g + 1;
      mas_cell u_cell (
        .clk        (clk),
        .my_idx     (4'(g)),
        .cmd        (cmd),
        .lower      (slots[Lo]),
        .upper      (slots[Hi]),
        .lower_swap ((g == 0) ? 1'b0 : swaps[Lo]),
        .up_in_range(5'(g + 1) < count),
        .slot       (slots[g]),
        .swap_up    (swaps[g])
      );
    end
  endgenerate

  assign cur  = slots[scan[3:0]];
  assign late = now_r - cur.atime;
  assign due  = cur.atime <= now_r;

  mas_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(late), .divisor(cur.period),
    .busy(div_busy), .quotient(quot)
  );

  // multiply result registered on leaving the divide wait (one multiplier, 33x24)
  assign jumps = {1'b0, quot} + 33'd1;
  assign prod  = 57'(jumps) * 57'(cur.period);
  assign nt    = {26'd0, cur.atime} + {1'b0, prod_r};

  assign stall = (state != S_IDLE);

  // result register is free this cycle
  assign out_ready_ok = !out_valid || !out_stall;

  // a result transaction is loaded at this edge
  assign out_load = out_ready_ok &&
                    ((state == S_EXEC) || (state == S_RESULT) ||
                     (state == S_SCAN && scan < count && due && late <= {24'd0, grace}));

  always_comb begin
    cmd = '0;
    cmd.bubble_odd = passes[0];
    if (state == S_SORT) cmd.bubble_en = 1'b1;
    if (state == S_EXEC && out_ready_ok) begin
      if (rq == mas_pkg::REQ_ADD && count < 5'(mas_pkg::AlarmSlots)) begin
        cmd.load = 1'b1;
        cmd.idx  = count[3:0];
        cmd.data = '{atime: at_r, period: per_r, tag: tag_r, kind: kind_r, cb: cb_r};
      end else if (rq == mas_pkg::REQ_DELETE && {1'b0, pos_r} < count) begin
        cmd.pull = 1'b1;
        cmd.idx  = pos_r;
      end else if (rq == mas_pkg::REQ_UPDATE && {1'b0, pos_r} < count) begin
        // take the entry out; it comes back at the end of the row next cycle
        cmd.pull = 1'b1;
        cmd.idx  = pos_r;
      end
    end
    if (state == S_UPDL) begin
      cmd.load = 1'b1;
      cmd.idx  = count[3:0] - 4'd1;
      cmd.data = upd_r;
    end
    if (state == S_SCAN && out_ready_ok && scan < count && due && cur.period == 24'd0) begin
      cmd.pull = 1'b1;
      cmd.idx  = scan[3:0];
    end
    if (state == S_ADV) begin
      cmd.load = 1'b1;
      cmd.idx  = scan[3:0];
      cmd.data = cur;
      cmd.data.atime = (nt[57:32] != 26'd0) ? 32'hFFFF_FFFF : nt[31:0];
    end
  end

  assign div_start = (state == S_SCAN) && out_ready_ok && scan < count && due &&
                     cur.period != 24'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (valid) begin
            rq     <= req_type;
            now_r  <= now_seconds;
            at_r   <= alarm_time;
            per_r  <= period_seconds;
            tag_r  <= message_tag;
            kind_r <= is_callback && callback_number != 5'd0 &&
                      callback_number <= 5'(mas_pkg::CallbackSlots);
            cb_r   <= (is_callback && callback_number != 5'd0 &&
                      callback_number <= 5'(mas_pkg::CallbackSlots)) ? callback_number : 5'd0;
            pos_r  <= position;
            scan   <= '0;
            nfire  <= '0;
            any_fire <= 1'b0;
            state  <= (req_type == mas_pkg::REQ_TICK) ? S_COUNT : S_EXEC;
          end
        end
        S_EXEC: begin
          // result is produced now; sorting follows for the table
          if (out_ready_ok) begin
            fired <= 1'b0; out_is_callback <= 1'b0; out_callback_number <= '0;
            last <= 1'b1;
            passes <= '0;
            case (rq)
              mas_pkg::REQ_ADD: begin
                out_time <= '0; out_tag <= '0;
                state <= S_SORT;
                if (count >= 5'(mas_pkg::AlarmSlots)) status <= mas_pkg::ST_FULL;
                else begin
                  status <= mas_pkg::ST_OK;
                  count  <= count + 5'd1;
                end
              end
              mas_pkg::REQ_DELETE: begin
                state <= S_SORT;
                if ({1'b0, pos_r} >= count) begin
                  status <= mas_pkg::ST_BAD_POS;
                  out_time <= '0; out_tag <= '0;
                end else begin
                  status   <= mas_pkg::ST_OK;
                  out_time <= slots[pos_r].atime;
                  out_tag  <= slots[pos_r].tag;
                  count    <= count - 5'd1;
                end
              end
              default: begin
                out_time <= '0; out_tag <= '0;
                if ({1'b0, pos_r} >= count) begin
                  status <= mas_pkg::ST_BAD_POS;
                  state  <= S_SORT;
                end else begin
                  status <= mas_pkg::ST_OK;
                  upd_r  <= '{atime: at_r, period: slots[pos_r].period, tag: tag_r,
                              kind: slots[pos_r].kind, cb: slots[pos_r].cb};
                  state  <= S_UPDL;
                end
              end
            endcase
          end
        end
        S_UPDL: state <= S_SORT;
        S_COUNT: begin
          // count the fires first so the final one can carry last
          if (scan >= count) begin
            scan  <= '0;
            state <= S_SCAN;
          end else begin
            if (due && late <= {24'd0, grace}) nfire <= nfire + 5'd1;
            scan <= scan + 5'd1;
          end
        end
        S_SCAN: begin
          if (scan >= count) begin
            passes <= '0;
            state  <= S_SORT;
          end else if (!due) begin
            scan <= scan + 5'd1;
          end else if (out_ready_ok) begin
            if (late <= {24'd0, grace}) begin
              status <= mas_pkg::ST_OK; fired <= 1'b1; last <= (nfire == 5'd1);
              out_time <= cur.atime; out_tag <= cur.tag;
              out_is_callback <= cur.kind; out_callback_number <= cur.cb;
              nfire <= nfire - 5'd1;
              any_fire <= 1'b1;
            end
            if (cur.period == 24'd0) count <= count - 5'd1;
            else state <= S_DIV;
          end
        end
        S_DIV: state <= S_DIVW;
        S_DIVW: if (!div_busy) begin
          prod_r <= prod;
          state  <= S_ADV;
        end
        S_ADV: begin
          scan  <= scan + 5'd1;
          state <= S_SCAN;
        end
        S_SORT: begin
          passes <= passes + 5'd1;
          if (passes == 5'(mas_pkg::AlarmSlots)) begin
            state <= (rq == mas_pkg::REQ_TICK && !any_fire) ? S_RESULT : S_IDLE;
          end
        end
        S_RESULT: begin
          if (out_ready_ok) begin
            // empty tick: one result with only last set
            status <= mas_pkg::ST_OK; fired <= 1'b0; last <= 1'b1;
            out_time <= '0; out_tag <= '0;
            out_is_callback <= 1'b0; out_callback_number <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> stall) else $error("accept while busy");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 5'(mas_pkg::AlarmSlots)) else $error("count overflow");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADV) |-> !div_busy) else $error("divide not done");
endmodule
`default_nettype wire

### dv/tb_multi_alarm_scheduler.sv
`default_nettype none
module tb_multi_alarm_scheduler;

  // one outgoing transaction of the result channel
  typedef struct packed {
    logic [1:0]  status;
    logic        fired;
    logic [31:0] atime;
    logic [15:0] tag;
    logic        kind;
    logic [4:0]  cb;
    logic        last;
  } alarm_rsp_t;

  typedef struct {
    logic [31:0] atime;
    logic [23:0] period;
    logic [15:0] tag;
    logic        kind;
    logic [4:0]  cb;
  } alarm_ent_t;

  // shadow alarm table plus the queue of results still owed by the block
  class alarm_scoreboard;
    alarm_ent_t  table_q[$];
    logic [7:0]  grace;
    alarm_rsp_t  owed[$];
    int          mismatches;
    int          checked;
    int          fires;

    function new();
      grace = 8'd2;
      mismatches = 0;
      checked = 0;
      fires = 0;
    endfunction

    function void owe(logic [1:0] st, logic fi, logic [31:0] t, logic [15:0] tg,
                      logic kd, logic [4:0] c, logic la);
      alarm_rsp_t r;
      r.status = st; r.fired = fi; r.atime = t; r.tag = tg;
      r.kind = kd; r.cb = c; r.last = la;
      owed = {owed, r};
    endfunction

    // place after every entry with trigger second at or below its own
    function void place(alarm_ent_t e);
      int p;
      p = table_q.size();
      while (p > 0 && table_q[p-1].atime > e.atime) p--;
      table_q.insert(p, e);
    endfunction

    function void note_request(logic [1:0] rq, logic [31:0] now, logic [31:0] at,
                               logic [23:0] per, logic [15:0] tg, logic kd,
                               logic [4:0] cbn, logic [3:0] pos);
      alarm_ent_t e;
      alarm_ent_t tmp[$];
      logic [31:0] late;
      logic [63:0] nt;
      int n;
      int i;
      case (rq)
        mas_pkg::REQ_ADD: begin
          if (table_q.size() >= mas_pkg::AlarmSlots) begin
            owe(mas_pkg::ST_FULL, 0, 0, 0, 0, 0, 1);
          end else begin
            // out-of-range callback slot demotes to a message alarm
            if (kd && (cbn == 0 || cbn > mas_pkg::CallbackSlots)) kd = 0;
            e.atime = at; e.period = per; e.tag = tg; e.kind = kd;
            e.cb = kd ? cbn : 5'd0;
            place(e);
            owe(mas_pkg::ST_OK, 0, 0, 0, 0, 0, 1);
          end
        end
        mas_pkg::REQ_DELETE: begin
          if (pos >= table_q.size()) begin
            owe(mas_pkg::ST_BAD_POS, 0, 0, 0, 0, 0, 1);
          end else begin
            owe(mas_pkg::ST_OK, 0, table_q[pos].atime, table_q[pos].tag, 0, 0, 1);
            table_q.delete(pos);
          end
        end
        mas_pkg::REQ_UPDATE: begin
          if (pos >= table_q.size()) begin
            owe(mas_pkg::ST_BAD_POS, 0, 0, 0, 0, 0, 1);
          end else begin
            e = table_q[pos];
            e.atime = at; e.tag = tg;
            table_q.delete(pos);
            place(e);
            owe(mas_pkg::ST_OK, 0, 0, 0, 0, 0, 1);
          end
        end
        default: begin
          n = 0;
          i = 0;
          while (i < table_q.size()) begin
            if (table_q[i].atime <= now) begin
              late = now - table_q[i].atime;
              if (late <= {24'd0, grace} && n < 16) begin
                owe(mas_pkg::ST_OK, 1, table_q[i].atime, table_q[i].tag, table_q[i].kind,
                    table_q[i].cb, 0);
                n++;
              end
              if (table_q[i].period != 0) begin
                nt = {32'd0, table_q[i].atime} +
                     (64'(late / table_q[i].period) + 64'd1) * 64'(table_q[i].period);
                table_q[i].atime = (nt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nt[31:0];
                i++;
              end else begin
                table_q.delete(i);
              end
            end else begin
              i++;
            end
          end
          // stable re-sort after repeating alarms moved forward
          tmp = table_q;
          table_q.delete();
          foreach (tmp[k]) place(tmp[k]);
          fires += n;
          if (n == 0) owe(mas_pkg::ST_OK, 0, 0, 0, 0, 0, 1);
          else owed[owed.size()-1].last = 1;
        end
      endcase
    endfunction

    function void check_result(alarm_rsp_t got);
      alarm_rsp_t w;
      checked++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: status=%0d fired=%0d",
                                       got.status, got.fired);
        return;
      end
      w = owed.pop_front();
      if (got !== w) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d: exp st=%0d f=%0d t=%h tag=%h k=%0d cb=%0d l=%0d",
                   checked, w.status, w.fired, w.atime, w.tag, w.kind, w.cb, w.last);
          $display("  got st=%0d f=%0d t=%h tag=%h k=%0d cb=%0d l=%0d",
                   got.status, got.fired, got.atime, got.tag, got.kind, got.cb, got.last);
        end
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        valid = 0;
  logic        stall;
  logic [1:0]  req_type = mas_pkg::REQ_TICK;
  logic [31:0] now_seconds = 0;
  logic [31:0] alarm_time = 0;
  logic [23:0] period_seconds = 0;
  logic [15:0] message_tag = 0;
  logic        is_callback = 0;
  logic [4:0]  callback_number = 0;
  logic [3:0]  position = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  status;
  logic        fired;
  logic [31:0] out_time;
  logic [15:0] out_tag;
  logic        out_is_callback;
  logic [4:0]  out_callback_number;
  logic        last;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [1:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  multi_alarm_scheduler dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  alarm_scoreboard sb = new();

  // stimulus and receiver controls
  bit quiet;          // no idling in the closing part
  int hold_cycles;    // long hold-off requested by the stimulus
  int n_sent;
  logic [31:0] clock_now;  // running notion of wall time for ticks

  // sample results at the edge; out_stall is what we drove for this edge
  always @(posedge clk) begin
    alarm_rsp_t r;
    if (!rst && out_valid && !out_stall) begin
      r.status = status; r.fired = fired; r.atime = out_time; r.tag = out_tag;
      r.kind = out_is_callback; r.cb = out_callback_number; r.last = last;
      sb.check_result(r);
    end
  end

  // result-side stall: random bursts, plus one long hold-off on request
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 9);
        out_stall <= 1;
        repeat (gap) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic write_grace(input logic [7:0] g);
    @(posedge clk);
    psel <= 1; pwrite <= 1; paddr <= 2'd0; pwdata <= {24'd0, g};
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.grace = g;
  endtask

  // wait until every owed result has come, then let the block settle
  task automatic drain();
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  // one request transaction; keeps valid high across back-to-back items
  task automatic send(input logic [1:0] rq, input logic [31:0] now, input logic [31:0] at,
                      input logic [23:0] per, input logic [15:0] tg, input logic kd,
                      input logic [4:0] cbn, input logic [3:0] pos, input bit may_idle);
    int gap;
    if (may_idle && !quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      valid <= 0;
      repeat (gap) @(posedge clk);
    end
    valid <= 1; req_type <= rq; now_seconds <= now; alarm_time <= at;
    period_seconds <= per; message_tag <= tg; is_callback <= kd;
    callback_number <= cbn; position <= pos;
    do @(posedge clk); while (stall);
    sb.note_request(rq, now, at, per, tg, kd, cbn, pos);
    n_sent++;
  endtask

  task automatic idle_sender();
    valid <= 0;
    @(posedge clk);
  endtask

  task automatic rand_add(input bit may_idle);
    send(mas_pkg::REQ_ADD, $urandom, clock_now + $urandom_range(0, 12),
         ($urandom_range(0, 2) == 0) ? 24'd0 : 24'($urandom_range(1, 6)),
         16'($urandom), 1'($urandom), 5'($urandom), 4'($urandom), may_idle);
  endtask

  task automatic rand_item(input bit may_idle);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) rand_add(may_idle);
    else if (pick < 7) begin
      clock_now = clock_now + $urandom_range(0, 5);
      send(mas_pkg::REQ_TICK, clock_now, $urandom, 24'($urandom), 16'($urandom),
           1'($urandom), 5'($urandom), 4'($urandom), may_idle);
    end else if (pick < 8) begin
      send(mas_pkg::REQ_DELETE, $urandom, $urandom, 24'($urandom), 16'($urandom),
           1'($urandom), 5'($urandom), 4'($urandom), may_idle);
    end else if (pick < 9) begin
      send(mas_pkg::REQ_UPDATE, $urandom, clock_now + $urandom_range(0, 10), 24'($urandom),
           16'($urandom), 1'($urandom), 5'($urandom), 4'($urandom), may_idle);
    end else begin
      // wide-field noise: full-range times and periods
      send(2'($urandom), $urandom, $urandom, 24'($urandom), 16'($urandom), 1'($urandom),
           5'($urandom), 4'($urandom), may_idle);
    end
  endtask

  initial begin
    logic [7:0] gvals [4];
    quiet = 0;
    hold_cycles = 0;
    n_sent = 0;
    clock_now = 32'd1000;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty tables, bad positions, kinds, callback edge values
    send(mas_pkg::REQ_TICK, 32'd0, 0, 0, 0, 0, 0, 0, 0);
    send(mas_pkg::REQ_DELETE, 0, 0, 0, 0, 0, 0, 4'd0, 0);
    send(mas_pkg::REQ_UPDATE, 0, 32'hFFFF_FFFF, 0, 16'hFFFF, 0, 0, 4'd15, 0);
    send(mas_pkg::REQ_ADD, 0, 32'd100, 24'd0, 16'h0001, 1, 5'd1, 0, 0);
    send(mas_pkg::REQ_ADD, 0, 32'd100, 24'd7, 16'h0002, 1, 5'd20, 0, 0);
    send(mas_pkg::REQ_ADD, 0, 32'd100, 24'hFF_FFFF, 16'h0003, 1, 5'd21, 0, 0);  // bad slot
    send(mas_pkg::REQ_ADD, 0, 32'd99, 24'd3, 16'h0004, 1, 5'd0, 0, 0);          // slot zero
    send(mas_pkg::REQ_ADD, 0, 32'd50, 24'd1, 16'hFFFF, 0, 5'd31, 0, 0);         // message kind
    send(mas_pkg::REQ_ADD, 0, 32'hFFFF_FFF0, 24'd10, 16'h0005, 1, 5'd5, 0, 0);
    send(mas_pkg::REQ_ADD, 0, 32'd0, 24'd0, 16'h0000, 0, 0, 0, 0);
    send(mas_pkg::REQ_UPDATE, 0, 32'd101, 0, 16'hABCD, 0, 0, 4'd0, 0);
    send(mas_pkg::REQ_DELETE, 0, 0, 0, 0, 0, 0, 4'd6, 0);
    send(mas_pkg::REQ_TICK, 32'd101, 0, 0, 0, 0, 0, 0, 0);     // fires within grace
    send(mas_pkg::REQ_TICK, 32'd200, 0, 0, 0, 0, 0, 0, 0);     // late alarms skipped
    send(mas_pkg::REQ_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0); // saturating advance
    // fill to full, then one more add
    while (sb.table_q.size() < mas_pkg::AlarmSlots)
      send(mas_pkg::REQ_ADD, 0, 32'd300, 24'd0, 16'($urandom), 1, 5'd3, 0, 0);
    send(mas_pkg::REQ_ADD, 0, 32'd1, 0, 0, 0, 0, 0, 0);
    send(mas_pkg::REQ_TICK, 32'd300, 0, 0, 0, 0, 0, 0, 0);     // many fires in one tick
    idle_sender();
    drain();

    // random phases across grace settings, extremes included
    gvals = '{8'd0, 8'd255, 8'd3, 8'd2};
    foreach (gvals[k]) begin
      write_grace(gvals[k]);
      repeat (40) rand_item(1);
      if (k == 1) begin
        // long receiver hold-off while items keep coming
        hold_cycles = 3000;
        repeat (12) rand_item(0);
      end
      if (k == 2) begin
        // sender pauses until everything owed has arrived
        idle_sender();
        while (sb.owed.size() != 0) @(posedge clk);
      end
      idle_sender();
      drain();
    end

    // closing part without idling
    quiet = 1;
    repeat (25) rand_item(0);
    idle_sender();
    drain();

    $display("sent %0d requests, checked %0d results including %0d alarm fires",
             n_sent, sb.checked, sb.fires);
    $display("grace settings 0, 2, 3, 255; full-table, bad-position and saturation cases");
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("multi_alarm_scheduler: match");
    end else begin
      $display("multi_alarm_scheduler: mismatch");
    end
    $finish;
  end

  // generous overall limit
  initial begin
    #20000000;
    $display("multi_alarm_scheduler: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
